FILE: hw/rtl/euler_to_quaternion_top_defines.svh
// assertion macros shared by the euler to quaternion checker
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH

// condition in the same cycle
`define E2Q_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("e2q check failed");

// condition in the next cycle
`define E2Q_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("e2q check failed");

`endif

FILE: hw/rtl/e2q_pkg.sv
// types, constants and tables of the euler to quaternion block
package e2q_pkg;
   localparam int ANGLE_WIDTH     = 16;
   localparam int OUT_WIDTH       = 16;
   localparam int TRIG_ITERATIONS = 16;

   localparam int CORDIC_WIDTH = 34;
   localparam int TRIG_WIDTH   = 17;
   localparam int PAIR_WIDTH   = 32;
   localparam int TRIPLE_WIDTH = 47;
   localparam int SUM_WIDTH    = 48;

   typedef logic signed [ANGLE_WIDTH-1:0]  angle_type;
   typedef logic signed [OUT_WIDTH-1:0]    quat_type;
   typedef logic signed [CORDIC_WIDTH-1:0] cordic_type;
   typedef logic signed [TRIG_WIDTH-1:0]   trig_type;
   typedef logic signed [PAIR_WIDTH-1:0]   pair_type;
   typedef logic signed [TRIPLE_WIDTH-1:0] triple_type;
   typedef logic signed [SUM_WIDTH-1:0]    sum_type;

   typedef struct packed {
      trig_type cy;
      trig_type sy;
      trig_type cp;
      trig_type sp;
      trig_type cr;
      trig_type sr;
   } trig_set_type;

   localparam cordic_type PI_Q13       = 34'sd25736;
   localparam cordic_type INV_GAIN_Q30 = 34'sd652032874;
   localparam cordic_type ONE_Q15      = 34'sd32768;

   localparam longint OUT_LIM  = (64'sd1 <<< (OUT_WIDTH - 1)) - 1;
   localparam longint OUT_HI_L = (OUT_LIM < 16384) ? OUT_LIM : 16384;
   localparam longint OUT_LO_L = (OUT_LIM < 16384) ? (-OUT_LIM - 1) : -16384;
   localparam sum_type OUT_HI  = sum_type'(OUT_HI_L);
   localparam sum_type OUT_LO  = sum_type'(OUT_LO_L);

   localparam int ATAN_ENTRIES = 30;
   localparam logic signed [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
      32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
      32'sd4194283, 32'sd2097149, 32'sd1048576, 32'sd524288, 32'sd262144,
      32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
      32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128,
      32'sd64, 32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2};
endpackage

FILE: hw/rtl/euler_to_quaternion_top.sv
// top level of the zyx euler angle to quaternion converter
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_yaw_angle, req_pitch_angle, req_roll_angle
//  rsp      out        rsp_valid/rsp_ready    rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z
//
//  one item per cycle sustained while rsp_ready is high; the latency comes from
//  the cordic pipeline (one stage per iteration) and the product stages
//  synchronous reset empties the pipeline; there is no other state
//  a stall at rsp holds the last stage; bubbles upstream still close up,
//  so req_ready stays high until every stage holds an item
module euler_to_quaternion_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  e2q_pkg::angle_type req_yaw_angle,
   input  e2q_pkg::angle_type req_pitch_angle,
   input  e2q_pkg::angle_type req_roll_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output e2q_pkg::quat_type  rsp_quat_w,
   output e2q_pkg::quat_type  rsp_quat_x,
   output e2q_pkg::quat_type  rsp_quat_y,
   output e2q_pkg::quat_type  rsp_quat_z
);
   import e2q_pkg::*;

   // half angle sines and cosines between the two segments
   trig_set_type trig;
   logic         trig_valid;
   logic         trig_ready;

   // clamp, cordic and q15 rounding
   e2q_half_trig u_trig (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .yaw_angle   (req_yaw_angle),
      .pitch_angle (req_pitch_angle),
      .roll_angle  (req_roll_angle),
      .out_valid   (trig_valid),
      .out_ready   (trig_ready),
      .trig        (trig)
   );

   // products, sums and output saturation; last stage is the output register
   e2q_quat_product u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_ready  (trig_ready),
      .trig      (trig),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .quat_w    (rsp_quat_w),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z)
   );
endmodule

FILE: hw/rtl/e2q_half_trig.sv
// clamp, pipelined cordic and rounding for the three half angles
module e2q_half_trig (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  e2q_pkg::angle_type    yaw_angle,
   input  e2q_pkg::angle_type    pitch_angle,
   input  e2q_pkg::angle_type    roll_angle,
   output logic                  out_valid,
   input  logic                  out_ready,
   output e2q_pkg::trig_set_type trig
);
   import e2q_pkg::*;

   localparam int N  = TRIG_ITERATIONS;
   localparam int NS = N + 2;

   cordic_type x_ff [0:N][0:2];
   cordic_type y_ff [0:N][0:2];
   cordic_type z_ff [0:N][0:2];
   trig_type   c_ff [0:2];
   trig_type   s_ff [0:2];
   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;
   angle_type     ang [0:2];

   assign ang[0] = yaw_angle;
   assign ang[1] = pitch_angle;
   assign ang[2] = roll_angle;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   genvar l, i;
   generate
      for (l = 0; l < 3; l++) begin : g_lane
         cordic_type a_in;
         cordic_type rx_in;
         cordic_type ry_in;

         // clamp to +-pi; the q13 angle read as q14 is the half angle
         always_comb begin
            a_in = {{(CORDIC_WIDTH-ANGLE_WIDTH){ang[l][ANGLE_WIDTH-1]}}, ang[l]};
            if (a_in > PI_Q13) begin
               a_in = PI_Q13;
            end else if (a_in < -PI_Q13) begin
               a_in = -PI_Q13;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[0] && in_valid) begin
               x_ff[0][l] <= INV_GAIN_Q30;
               y_ff[0][l] <= '0;
               z_ff[0][l] <= a_in <<< 16;
            end
         end

         for (i = 0; i < N; i++) begin : g_iter
            cordic_type xs;
            cordic_type ys;
            cordic_type at;
            assign xs = x_ff[i][l] >>> i;
            assign ys = y_ff[i][l] >>> i;
            assign at = cordic_type'(ATAN_Q30[i]);
            always_ff @(posedge clock) begin
               if (rdy[i+1] && v_ff[i]) begin
                  if (z_ff[i][l] >= 0) begin
                     x_ff[i+1][l] <= x_ff[i][l] - ys;
                     y_ff[i+1][l] <= y_ff[i][l] + xs;
                     z_ff[i+1][l] <= z_ff[i][l] - at;
                  end else begin
                     x_ff[i+1][l] <= x_ff[i][l] + ys;
                     y_ff[i+1][l] <= y_ff[i][l] - xs;
                     z_ff[i+1][l] <= z_ff[i][l] + at;
                  end
               end
            end
         end

         // q30 to q15, halves toward +inf, clamp to +-1
         always_comb begin
            rx_in = (x_ff[N][l] + 34'sd16384) >>> 15;
            ry_in = (y_ff[N][l] + 34'sd16384) >>> 15;
            if (rx_in > ONE_Q15) rx_in = ONE_Q15;
            else if (rx_in < -ONE_Q15) rx_in = -ONE_Q15;
            if (ry_in > ONE_Q15) ry_in = ONE_Q15;
            else if (ry_in < -ONE_Q15) ry_in = -ONE_Q15;
         end

         always_ff @(posedge clock) begin
            if (rdy[NS-1] && v_ff[NS-2]) begin
               c_ff[l] <= rx_in[TRIG_WIDTH-1:0];
               s_ff[l] <= ry_in[TRIG_WIDTH-1:0];
            end
         end
      end
   endgenerate

   assign trig.cy = c_ff[0];
   assign trig.sy = s_ff[0];
   assign trig.cp = c_ff[1];
   assign trig.sp = s_ff[1];
   assign trig.cr = c_ff[2];
   assign trig.sr = s_ff[2];
endmodule

FILE: hw/rtl/e2q_quat_product.sv
// triple products, sums and output rounding of the quaternion
module e2q_quat_product (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  e2q_pkg::trig_set_type trig,
   output logic                  out_valid,
   input  logic                  out_ready,
   output e2q_pkg::quat_type     quat_w,
   output e2q_pkg::quat_type     quat_x,
   output e2q_pkg::quat_type     quat_y,
   output e2q_pkg::quat_type     quat_z
);
   import e2q_pkg::*;

   localparam int NS = 4;

   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;

   pair_type   cc_ff, ss_ff, cs_ff, sc_ff;
   trig_type   cr_ff, sr_ff;
   triple_type t_ff [0:7];
   sum_type    s_ff [0:3];
   quat_type   q_ff [0:3];

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   logic signed [2*TRIG_WIDTH-1:0] cc_in, ss_in, cs_in, sc_in;
   assign cc_in = trig.cy * trig.cp;
   assign ss_in = trig.sy * trig.sp;
   assign cs_in = trig.cy * trig.sp;
   assign sc_in = trig.sy * trig.cp;

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         cc_ff <= cc_in[PAIR_WIDTH-1:0];
         ss_ff <= ss_in[PAIR_WIDTH-1:0];
         cs_ff <= cs_in[PAIR_WIDTH-1:0];
         sc_ff <= sc_in[PAIR_WIDTH-1:0];
         cr_ff <= trig.cr;
         sr_ff <= trig.sr;
      end
   end

   logic signed [PAIR_WIDTH+TRIG_WIDTH-1:0] t_in [0:7];
   assign t_in[0] = cc_ff * cr_ff;
   assign t_in[1] = ss_ff * sr_ff;
   assign t_in[2] = cc_ff * sr_ff;
   assign t_in[3] = ss_ff * cr_ff;
   assign t_in[4] = sc_ff * sr_ff;
   assign t_in[5] = cs_ff * cr_ff;
   assign t_in[6] = sc_ff * cr_ff;
   assign t_in[7] = cs_ff * sr_ff;

   always_ff @(posedge clock) begin
      if (rdy[1] && v_ff[0]) begin
         for (int j = 0; j < 8; j++) begin
            t_ff[j] <= t_in[j][TRIPLE_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2] && v_ff[1]) begin
         s_ff[0] <= sum_type'(t_ff[0]) + sum_type'(t_ff[1]);
         s_ff[1] <= sum_type'(t_ff[2]) - sum_type'(t_ff[3]);
         s_ff[2] <= sum_type'(t_ff[4]) + sum_type'(t_ff[5]);
         s_ff[3] <= sum_type'(t_ff[6]) - sum_type'(t_ff[7]);
      end
   end

   // q45 to q14, halves toward +inf, saturate
   sum_type r_in [0:3];
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         r_in[j] = (s_ff[j] + (48'sd1 <<< 30)) >>> 31;
         if (r_in[j] > OUT_HI) r_in[j] = OUT_HI;
         else if (r_in[j] < OUT_LO) r_in[j] = OUT_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3] && v_ff[2]) begin
         for (int j = 0; j < 4; j++) begin
            q_ff[j] <= r_in[j][OUT_WIDTH-1:0];
         end
      end
   end

   assign quat_w = q_ff[0];
   assign quat_x = q_ff[1];
   assign quat_y = q_ff[2];
   assign quat_z = q_ff[3];
endmodule

FILE: hw/rtl/e2q_checker.sv
// port level checks of the euler to quaternion top, bound to it
`include "euler_to_quaternion_top_defines.svh"

module e2q_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input e2q_pkg::quat_type  rsp_quat_w,
   input e2q_pkg::quat_type  rsp_quat_x,
   input e2q_pkg::quat_type  rsp_quat_y,
   input e2q_pkg::quat_type  rsp_quat_z
);
   import e2q_pkg::*;

   logic in_range;
   assign in_range = ($signed(rsp_quat_w) <= 16384) && ($signed(rsp_quat_w) >= -16384)
      && ($signed(rsp_quat_x) <= 16384) && ($signed(rsp_quat_x) >= -16384)
      && ($signed(rsp_quat_y) <= 16384) && ($signed(rsp_quat_y) >= -16384)
      && ($signed(rsp_quat_z) <= 16384) && ($signed(rsp_quat_z) >= -16384);

   `E2Q_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `E2Q_ASSERT_NOW(a_rsp_range, clock, reset, rsp_valid, in_range)
   `E2Q_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `E2Q_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_valid, req_ready)
endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (.*);

FILE: tb/euler_to_quaternion_top_test.sv
// self-checking testbench of the euler to quaternion converter
module euler_to_quaternion_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import e2q_pkg::*;

   localparam int ANGLE_MAX = 25736;
   localparam int RANDOM_ITEMS = 650;
   localparam int DRAIN_CYCLES = TRIG_ITERATIONS + 40;

   // one orientation sample and the quaternion it should produce
   typedef struct {
      angle_type yaw;
      angle_type pitch;
      angle_type roll;
      bit        known;
      quat_type  w, x, y, z;
   } sample_row_type;

   typedef struct {
      quat_type w, x, y, z;
   } quat_set_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   angle_type req_yaw_angle;
   angle_type req_pitch_angle;
   angle_type req_roll_angle;
   logic      rsp_valid;
   logic      rsp_ready;
   quat_type  rsp_quat_w;
   quat_type  rsp_quat_x;
   quat_type  rsp_quat_y;
   quat_type  rsp_quat_z;

   quat_set_type   pending_quats[$];
   sample_row_type sample_table[$];
   int             error_count;
   bit             hold_off;

   euler_to_quaternion_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_yaw_angle(req_yaw_angle), .req_pitch_angle(req_pitch_angle),
      .req_roll_angle(req_roll_angle),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z)
   );

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // arithmetic shift right with floor, done on 64-bit signed values
   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // cosine and sine of half the angle, q15, from a rotation-mode cordic
   task automatic half_angle_trig(input angle_type angle, output longint c,
                                  output longint s);
      longint a, zr, xr, yr, xs, ys;
      a  = clip(longint'(angle), -ANGLE_MAX, ANGLE_MAX);
      zr = a * 65536;
      xr = 652032874;
      yr = 0;
      for (int i = 0; i < TRIG_ITERATIONS && i < ATAN_ENTRIES; i++) begin
         xs = shift_floor(xr, i);
         ys = shift_floor(yr, i);
         if (zr >= 0) begin
            xr = xr - ys;
            yr = yr + xs;
            zr = zr - longint'(ATAN_Q30[i]);
         end else begin
            xr = xr + ys;
            yr = yr - xs;
            zr = zr + longint'(ATAN_Q30[i]);
         end
      end
      c = clip(shift_floor(xr + (64'sd1 <<< 14), 15), -32768, 32768);
      s = clip(shift_floor(yr + (64'sd1 <<< 14), 15), -32768, 32768);
   endtask

   // q45 triple product sum to saturated q14
   function automatic quat_type to_q14(longint q45);
      longint v;
      v = clip(shift_floor(q45 + (64'sd1 <<< 30), 31), -16384, 16384);
      v = clip(v, OUT_LO_L, OUT_HI_L);
      return quat_type'(v);
   endfunction

   task automatic predict_quat(input angle_type yaw, input angle_type pitch,
                               input angle_type roll, output quat_set_type q);
      longint cy, sy, cp, sp, cr, sr;
      half_angle_trig(yaw, cy, sy);
      half_angle_trig(pitch, cp, sp);
      half_angle_trig(roll, cr, sr);
      q.w = to_q14(cy * cp * cr + sy * sp * sr);
      q.x = to_q14(cy * cp * sr - sy * sp * cr);
      q.y = to_q14(sy * cp * sr + cy * sp * cr);
      q.z = to_q14(sy * cp * cr - cy * sp * sr);
   endtask

   function automatic sample_row_type row(int yaw, int pitch, int roll);
      sample_row_type r;
      r.yaw = angle_type'(yaw);
      r.pitch = angle_type'(pitch);
      r.roll = angle_type'(roll);
      r.known = 1'b0;
      return r;
   endfunction

   function automatic sample_row_type known_row(int yaw, int pitch, int roll,
                                               int w, int x, int y, int z);
      sample_row_type r;
      r = row(yaw, pitch, roll);
      r.known = 1'b1;
      r.w = quat_type'(w);
      r.x = quat_type'(x);
      r.y = quat_type'(y);
      r.z = quat_type'(z);
      return r;
   endfunction

   // random angle: mostly legal range, sometimes raw bits that may lie beyond pi, or exactly +-pi
   function automatic angle_type random_angle();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return angle_type'($urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX);
      if (pick < 9) return angle_type'($urandom);
      return ($urandom_range(0, 1) != 0) ? angle_type'(ANGLE_MAX) : angle_type'(-ANGLE_MAX);
   endfunction

   // reset, then drive the directed table followed by random items
   initial begin
      quat_set_type   q;
      sample_row_type r;
      int             gap;
      int             burst;
      int             drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_yaw_angle = '0;
      req_pitch_angle = '0;
      req_roll_angle = '0;
      error_count = 0;

      // zero angles: identity, but the cordic leaves a sine of minus one lsb,
      // which shows up as -1 in x and z
      sample_table.push_back(known_row(0, 0, 0, 16384, -1, 0, -1));
      // a single angle of +-pi alone (pitch, yaw or roll): half angle is pi/2
      sample_table.push_back(row(0, ANGLE_MAX, 0));
      sample_table.push_back(row(0, -ANGLE_MAX, 0));
      sample_table.push_back(row(ANGLE_MAX, 0, 0));
      sample_table.push_back(row(-ANGLE_MAX, 0, 0));
      sample_table.push_back(row(0, 0, ANGLE_MAX));
      sample_table.push_back(row(0, 0, -ANGLE_MAX));
      // angles beyond pi clamp to the pi extremes
      sample_table.push_back(row(32767, -32768, 30000));
      sample_table.push_back(row(-32768, 32767, -30000));
      sample_table.push_back(row(25737, 25737, -25737));
      sample_table.push_back(row(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX));
      sample_table.push_back(row(-ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX));
      sample_table.push_back(row(-1, 1, -1));
      sample_table.push_back(row(12868, 12868, 12868));
      sample_table.push_back(row(-12868, 6434, 19302));
      sample_table.push_back(row(8192, -8192, 4096));
      sample_table.push_back(row(16'h5555, 16'h2aaa, -16'sd21846));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      burst = 0;
      for (int n = 0; n < sample_table.size() + RANDOM_ITEMS; n++) begin
         if (n < sample_table.size()) begin
            r = sample_table[n];
         end else begin
            r = row(0, 0, 0);
            r.yaw = random_angle();
            r.pitch = random_angle();
            r.roll = random_angle();
         end
         // random gaps between bursts of back-to-back items
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst--;
         predict_quat(r.yaw, r.pitch, r.roll, q);
         if (r.known && (q.w != r.w || q.x != r.x || q.y != r.y || q.z != r.z)) begin
            $display("%0t table row %0d: typed %0d %0d %0d %0d, predicted %0d %0d %0d %0d",
                     $time, n, r.w, r.x, r.y, r.z, q.w, q.x, q.y, q.z);
            error_count++;
         end
         // drive at this edge and hold until the accepting edge
         req_valid <= 1'b1;
         req_yaw_angle <= r.yaw;
         req_pitch_angle <= r.pitch;
         req_roll_angle <= r.roll;
         do @(posedge clock); while (!req_ready);
         pending_quats.push_back(q);
      end
      req_valid <= 1'b0;

      drain = 0;
      while (pending_quats.size() != 0 && drain < 200000) begin
         @(posedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_quats.size() == 0)
         $display("euler_to_quaternion_top_test: done, clean");
      else
         $display("euler_to_quaternion_top_test: done, errors");
      $finish;
   end

   // receiver: stretches with no stalls, random stalls, plus one long hold-off so the pipe fills
   initial begin
      int cycle_count;
      rsp_ready = 1'b0;
      hold_off = 1'b0;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= 200 && cycle_count < 280) hold_off = 1'b1;
         else hold_off = 1'b0;
         if (hold_off)
            rsp_ready <= 1'b0;
         else if ((cycle_count / 64) % 3 == 0)
            rsp_ready <= 1'b1;  // stretch with no stalls
         else
            rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      quat_set_type q;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_quats.size() == 0) begin
            $display("%0t unexpected item: actual %0d %0d %0d %0d", $time,
                     rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            error_count++;
         end else begin
            q = pending_quats.pop_front();
            if (rsp_quat_w !== q.w) begin
               $display("%0t quat_w: expected %0d actual %0d", $time, q.w, rsp_quat_w);
               error_count++;
            end
            if (rsp_quat_x !== q.x) begin
               $display("%0t quat_x: expected %0d actual %0d", $time, q.x, rsp_quat_x);
               error_count++;
            end
            if (rsp_quat_y !== q.y) begin
               $display("%0t quat_y: expected %0d actual %0d", $time, q.y, rsp_quat_y);
               error_count++;
            end
            if (rsp_quat_z !== q.z) begin
               $display("%0t quat_z: expected %0d actual %0d", $time, q.z, rsp_quat_z);
               error_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("euler_to_quaternion_top_test: done, errors");
      $finish;
   end
endmodule
